[rtl/core/cdss_pkg.sv]
// shared types, constants and tables of the critically damped spring step
package cdss_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned POS_W         = 32;
  localparam int unsigned DT_W          = 17;
  localparam int unsigned HL_W          = 23;

  localparam logic [63:0] LN2_Q32   = 64'd2977044472;
  localparam logic [63:0] ONE_Q32   = 64'd1 << 32;
  localparam logic [63:0] EXP_LIMIT = LN2_Q32 * 64'd41;
  localparam logic [63:0] SAT_CAP   = 64'd1 << 62;

  localparam int unsigned RED_W       = 6;
  localparam int unsigned IDX_W       = 3;
  localparam int unsigned TAY_N_W     = 4;
  localparam int unsigned TAY_TERMS   = 14;
  localparam int unsigned RECIP_SHIFT = 37;
  localparam int unsigned RECIP_W     = 38;
  localparam logic [63:0] RECIP_ONE   = 64'd1 << RECIP_SHIFT;

  typedef enum logic [2:0] {
    OP_X,
    OP_TMUL,
    OP_TDIV,
    OP_J1,
    OP_NV1,
    OP_NV2,
    OP_NP1,
    OP_NP2
  } op_e;

  typedef struct packed {
    logic               load;
    logic               div_start;
    logic               mul_start;
    op_e                mul_op;
    logic               exp_chk;
    logic               red_step;
    logic [IDX_W-1:0]   red_idx;
    logic               tay_init;
    logic [TAY_N_W-1:0] tay_n;
    logic               exp_fin;
    logic               out_load;
    logic               out_zero;
  } cmd_t;

  typedef struct packed {
    logic dt_zero;
    logic div_done;
    logic mul_done;
    logic exp_big;
  } sts_t;

  // ceil(2^37 / n), exact floor division of values below 2^32 by n
  function automatic logic [RECIP_W-1:0] recip(input logic [TAY_N_W-1:0] n);
    logic [RECIP_W-1:0] r;
    case (n)
      4'd1:    r = RECIP_W'(RECIP_ONE / 64'd1);
      4'd2:    r = RECIP_W'((RECIP_ONE + 64'd1) / 64'd2);
      4'd3:    r = RECIP_W'((RECIP_ONE + 64'd2) / 64'd3);
      4'd4:    r = RECIP_W'((RECIP_ONE + 64'd3) / 64'd4);
      4'd5:    r = RECIP_W'((RECIP_ONE + 64'd4) / 64'd5);
      4'd6:    r = RECIP_W'((RECIP_ONE + 64'd5) / 64'd6);
      4'd7:    r = RECIP_W'((RECIP_ONE + 64'd6) / 64'd7);
      4'd8:    r = RECIP_W'((RECIP_ONE + 64'd7) / 64'd8);
      4'd9:    r = RECIP_W'((RECIP_ONE + 64'd8) / 64'd9);
      4'd10:   r = RECIP_W'((RECIP_ONE + 64'd9) / 64'd10);
      4'd11:   r = RECIP_W'((RECIP_ONE + 64'd10) / 64'd11);
      4'd12:   r = RECIP_W'((RECIP_ONE + 64'd11) / 64'd12);
      4'd13:   r = RECIP_W'((RECIP_ONE + 64'd12) / 64'd13);
      4'd14:   r = RECIP_W'((RECIP_ONE + 64'd13) / 64'd14);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[rtl/core/cdss_upd_if.sv]
// input channel: position, target and time step
interface cdss_upd_if;
  logic                                valid;
  logic                                ready;
  logic signed [cdss_pkg::POS_W-1:0]   current_position;
  logic signed [cdss_pkg::POS_W-1:0]   target_position;
  logic        [cdss_pkg::DT_W-1:0]    time_step;

  modport source (output valid, current_position, target_position, time_step, input ready);
  modport sink   (input valid, current_position, target_position, time_step, output ready);
endinterface

[rtl/core/cdss_res_if.sv]
// result channel: new position and velocity
interface cdss_res_if;
  logic                              valid;
  logic                              ready;
  logic signed [cdss_pkg::POS_W-1:0] new_position;
  logic signed [cdss_pkg::POS_W-1:0] new_velocity;

  modport source (output valid, new_position, new_velocity, input ready);
  modport sink   (input valid, new_position, new_velocity, output ready);
endinterface

[rtl/core/cdss_mul.sv]
// 64x64 unsigned multiplier, one 32x32 partial product per cycle
module cdss_mul (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [63:0]  a_i,
  input  logic [63:0]  b_i,
  output logic         done_o,
  output logic [127:0] prod_o
);
  logic [1:0]   cnt_q, cnt_d;
  logic         busy_q, busy_d;
  logic         done_q, done_d;
  logic [127:0] acc_q, acc_d;
  logic [31:0]  pa, pb;
  logic [63:0]  pp;
  logic [127:0] pp_sh;

  always_comb begin
    pa = cnt_q[0] ? a_i[63:32] : a_i[31:0];
    pb = cnt_q[1] ? b_i[63:32] : b_i[31:0];
    pp = 64'(pa) * 64'(pb);
    case (cnt_q)
      2'd0:    pp_sh = {64'd0, pp};
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
  end

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    acc_d  = acc_q;
    if (start_i) begin
      cnt_d  = '0;
      busy_d = 1'b1;
      acc_d  = '0;
    end else if (busy_q) begin
      acc_d = acc_q + pp_sh;
      cnt_d = cnt_q + 2'd1;
      if (cnt_q == 2'd3) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;
endmodule

[rtl/core/cdss_div.sv]
// bit-serial divider for the damping rate ln2 / half_life
module cdss_div
  #(parameter int unsigned FracBits = cdss_pkg::FRAC_BITS_DEF)
  (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [cdss_pkg::HL_W-1:0]   hl_i,
  output logic                        done_o,
  output logic [33+FracBits-1:0]      quo_o
);
  import cdss_pkg::*;

  localparam int unsigned NUM_W = 33 + FracBits;
  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [HL_W-1:0]  rem_q, rem_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [HL_W-1:0]  dvs;
  logic [NUM_W-1:0] num;
  logic [HL_W:0]    rem_sh;
  logic [HL_W:0]    rem_sub;
  logic             ge;

  always_comb begin
    dvs     = (hl_i == '0) ? HL_W'(1) : hl_i;
    num     = (NUM_W'(LN2_Q32) << FracBits) + NUM_W'(hl_i >> 1);
    rem_sh  = {rem_q, quo_q[NUM_W-1]};
    rem_sub = rem_sh - {1'b0, dvs};
    ge      = rem_sh >= {1'b0, dvs};
  end

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      cnt_d  = CNT_W'(NUM_W);
      busy_d = 1'b1;
      rem_d  = '0;
      quo_d  = num;
    end else if (busy_q) begin
      rem_d = ge ? rem_sub[HL_W-1:0] : rem_sh[HL_W-1:0];
      quo_d = {quo_q[NUM_W-2:0], ge};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule

[rtl/core/cdss_dp.sv]
// datapath: operand registers, shared multiplier, divider and result registers
module cdss_dp
  #(parameter int unsigned FracBits = cdss_pkg::FRAC_BITS_DEF)
  (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  cdss_pkg::cmd_t                     cmd_i,
  output cdss_pkg::sts_t                     sts_o,
  input  logic                               cfg_we_i,
  input  logic        [cdss_pkg::HL_W-1:0]   cfg_wdata_i,
  input  logic signed [cdss_pkg::POS_W-1:0]  current_position_i,
  input  logic signed [cdss_pkg::POS_W-1:0]  target_position_i,
  input  logic        [cdss_pkg::DT_W-1:0]   time_step_i,
  output logic signed [cdss_pkg::POS_W-1:0]  new_position_o,
  output logic signed [cdss_pkg::POS_W-1:0]  new_velocity_o
);
  import cdss_pkg::*;

  localparam int unsigned UP_SH = 32 - FracBits;
  localparam int unsigned NUM_W = 33 + FracBits;
  localparam logic signed [64:0] CAP65 = $signed({1'b0, SAT_CAP});

  function automatic logic signed [64:0] ext65(input logic signed [63:0] v);
    return {v[63], v};
  endfunction

  function automatic logic signed [63:0] sat62(input logic signed [64:0] v);
    logic signed [63:0] r;
    if (v > CAP65) r = $signed(SAT_CAP);
    else if (v < -CAP65) r = -$signed(SAT_CAP);
    else r = v[63:0];
    return r;
  endfunction

  function automatic logic signed [POS_W-1:0] to_out(input logic signed [63:0] v);
    logic signed [64:0]      b;
    logic signed [64:0]      q;
    logic signed [POS_W-1:0] r;
    b = ext65(v) + (65'sd1 <<< (UP_SH - 1));
    q = b >>> UP_SH;
    if (q > 65'sd2147483647) r = 32'sh7fffffff;
    else if (q < -65'sd2147483648) r = 32'sh80000000;
    else r = q[POS_W-1:0];
    return r;
  endfunction

  logic        [HL_W-1:0]  hl_q;
  logic signed [POS_W-1:0] vel_q;
  logic signed [POS_W-1:0] pos_q, tgt_q;
  logic        [DT_W-1:0]  dt_q;
  logic        [63:0]      y_q, x_q, r_q;
  logic signed [63:0]      e_q, j1_q, tmp_q, nv_q, np_q;
  logic        [RED_W-1:0] k_q;
  logic        [32:0]      term_q, a_q;
  logic signed [35:0]      sum_q;
  logic signed [POS_W-1:0] npos_q, nvel_q;

  logic signed [32:0]      diff;
  logic signed [63:0]      j0, v64, tgt64;
  logic        [63:0]      dt32;
  logic signed [63:0]      op_a, op_b;
  logic        [63:0]      mag_a, mag_b;
  logic                    prod_neg;
  logic                    mul_done, div_done;
  logic        [127:0]     prod;
  logic        [NUM_W-1:0] quo;
  logic        [63:0]      mag62;
  logic signed [63:0]      smul;
  logic        [63:0]      red_cmp;
  logic signed [63:0]      sum64, e_new;
  logic        [32:0]      tnew;
  logic signed [POS_W-1:0] pos_out, vel_out;

  always_comb begin
    diff  = {pos_q[POS_W-1], pos_q} - {tgt_q[POS_W-1], tgt_q};
    j0    = {{31{diff[32]}}, diff} <<< UP_SH;
    v64   = {{32{vel_q[POS_W-1]}}, vel_q} <<< UP_SH;
    tgt64 = {{32{tgt_q[POS_W-1]}}, tgt_q} <<< UP_SH;
    dt32  = 64'(dt_q) << UP_SH;
  end

  always_comb begin
    unique case (cmd_i.mul_op) inside
      OP_X: begin
        op_a = $signed(y_q);
        op_b = $signed(dt32);
      end
      OP_TMUL: begin
        op_a = $signed(64'(term_q));
        op_b = $signed(r_q);
      end
      OP_TDIV: begin
        op_a = $signed(64'(a_q));
        op_b = $signed(64'(recip(cmd_i.tay_n)));
      end
      OP_J1: begin
        op_a = j0;
        op_b = $signed(y_q);
      end
      OP_NV1: begin
        op_a = j1_q;
        op_b = $signed(x_q);
      end
      OP_NP1: begin
        op_a = j1_q;
        op_b = $signed(dt32);
      end
      OP_NV2, OP_NP2: begin
        op_a = e_q;
        op_b = tmp_q;
      end
    endcase
    mag_a    = op_a[63] ? 64'(-op_a) : 64'(op_a);
    mag_b    = op_b[63] ? 64'(-op_b) : 64'(op_b);
    prod_neg = op_a[63] ^ op_b[63];
  end

  cdss_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (mag_a),
    .b_i     (mag_b),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  cdss_div #(.FracBits(FracBits)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .hl_i    (hl_q),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  always_comb begin
    mag62   = (|prod[127:94]) ? SAT_CAP : {2'b00, prod[93:32]};
    smul    = prod_neg ? -$signed(mag62) : $signed(mag62);
    red_cmp = LN2_Q32 << cmd_i.red_idx;
    sum64   = {{28{sum_q[35]}}, sum_q};
    e_new   = (k_q == '0) ? sum64
                          : (sum64 + (64'sd1 <<< (k_q - RED_W'(1)))) >>> k_q;
    tnew    = prod[RECIP_SHIFT+32:RECIP_SHIFT];
    pos_out = cmd_i.out_zero ? pos_q : to_out(np_q);
    vel_out = cmd_i.out_zero ? vel_q : to_out(nv_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hl_q  <= HL_W'(1) << FracBits;
      vel_q <= '0;
    end else begin
      if (cfg_we_i) begin
        hl_q <= cfg_wdata_i;
      end
      if (cmd_i.out_load) begin
        vel_q <= vel_out;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pos_q <= current_position_i;
      tgt_q <= target_position_i;
      dt_q  <= time_step_i;
    end
    if (div_done) begin
      y_q <= 64'(quo);
    end
    if (cmd_i.exp_chk) begin
      if (x_q >= EXP_LIMIT) begin
        e_q <= '0;
      end else begin
        r_q <= x_q;
        k_q <= '0;
      end
    end
    if (cmd_i.red_step && (r_q >= red_cmp)) begin
      r_q                <= r_q - red_cmp;
      k_q[cmd_i.red_idx] <= 1'b1;
    end
    if (cmd_i.tay_init) begin
      term_q <= ONE_Q32[32:0];
      sum_q  <= $signed({3'b000, ONE_Q32[32:0]});
    end
    if (cmd_i.exp_fin) begin
      e_q <= e_new;
    end
    if (mul_done) begin
      unique case (cmd_i.mul_op)
        OP_X:    x_q <= 64'(smul);
        OP_TMUL: a_q <= prod[64:32];
        OP_TDIV: begin
          term_q <= tnew;
          if (cmd_i.tay_n[0]) sum_q <= sum_q - $signed({3'b000, tnew});
          else sum_q <= sum_q + $signed({3'b000, tnew});
        end
        OP_J1:   j1_q  <= sat62(ext65(v64) + ext65(smul));
        OP_NV1:  tmp_q <= sat62(ext65(v64) - ext65(smul));
        OP_NV2:  nv_q  <= smul;
        OP_NP1:  tmp_q <= sat62(ext65(j0) + ext65(smul));
        OP_NP2:  np_q  <= sat62(ext65(smul) + ext65(tgt64));
      endcase
    end
    if (cmd_i.out_load) begin
      npos_q <= pos_out;
      nvel_q <= vel_out;
    end
  end

  always_comb begin
    sts_o.dt_zero  = (dt_q == '0);
    sts_o.div_done = div_done;
    sts_o.mul_done = mul_done;
    sts_o.exp_big  = (x_q >= EXP_LIMIT);
  end

  assign new_position_o = npos_q;
  assign new_velocity_o = nvel_q;
endmodule

[rtl/core/cdss_ctrl.sv]
// controller: sequences divide, range reduction, series and spring products
module cdss_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  cdss_pkg::sts_t sts_i,
  output cdss_pkg::cmd_t cmd_o
);
  import cdss_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_CHK     = 4'd1;
  localparam logic [3:0] S_DIV     = 4'd2;
  localparam logic [3:0] S_MSTART  = 4'd3;
  localparam logic [3:0] S_MWAIT   = 4'd4;
  localparam logic [3:0] S_EXPCHK  = 4'd5;
  localparam logic [3:0] S_RED     = 4'd6;
  localparam logic [3:0] S_TAYINIT = 4'd7;
  localparam logic [3:0] S_EXPFIN  = 4'd8;
  localparam logic [3:0] S_FIN     = 4'd9;

  logic [3:0]         state_q, state_d;
  op_e                op_q, op_d;
  logic [TAY_N_W-1:0] n_q, n_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic               zero_q, zero_d;
  logic               out_valid_q, out_valid_d;

  always_comb begin
    state_d        = state_q;
    op_d           = op_q;
    n_d            = n_q;
    idx_d          = idx_q;
    zero_d         = zero_q;
    cmd_o          = '0;
    cmd_o.mul_op   = op_q;
    cmd_o.tay_n    = n_q;
    cmd_o.red_idx  = idx_q;
    cmd_o.out_zero = zero_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          zero_d     = 1'b0;
          state_d    = S_CHK;
        end
      end
      S_CHK: begin
        if (sts_i.dt_zero) begin
          zero_d  = 1'b1;
          state_d = S_FIN;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          op_d    = OP_X;
          state_d = S_MSTART;
        end
      end
      S_MSTART: begin
        cmd_o.mul_start = 1'b1;
        state_d         = S_MWAIT;
      end
      S_MWAIT: begin
        if (sts_i.mul_done) begin
          state_d = S_MSTART;
          unique case (op_q)
            OP_X:    state_d = S_EXPCHK;
            OP_TMUL: op_d = OP_TDIV;
            OP_TDIV: begin
              if (n_q == TAY_N_W'(TAY_TERMS)) begin
                state_d = S_EXPFIN;
              end else begin
                n_d  = n_q + TAY_N_W'(1);
                op_d = OP_TMUL;
              end
            end
            OP_J1:   op_d = OP_NV1;
            OP_NV1:  op_d = OP_NV2;
            OP_NV2:  op_d = OP_NP1;
            OP_NP1:  op_d = OP_NP2;
            OP_NP2:  state_d = S_FIN;
          endcase
        end
      end
      S_EXPCHK: begin
        cmd_o.exp_chk = 1'b1;
        if (sts_i.exp_big) begin
          op_d    = OP_J1;
          state_d = S_MSTART;
        end else begin
          idx_d   = IDX_W'(RED_W - 1);
          state_d = S_RED;
        end
      end
      S_RED: begin
        cmd_o.red_step = 1'b1;
        if (idx_q == '0) begin
          state_d = S_TAYINIT;
        end else begin
          idx_d = idx_q - IDX_W'(1);
        end
      end
      S_TAYINIT: begin
        cmd_o.tay_init = 1'b1;
        n_d            = TAY_N_W'(1);
        op_d           = OP_TMUL;
        state_d        = S_MSTART;
      end
      S_EXPFIN: begin
        cmd_o.exp_fin = 1'b1;
        op_d          = OP_J1;
        state_d       = S_MSTART;
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.out_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_X;
      n_q         <= '0;
      idx_q       <= '0;
      zero_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      n_q         <= n_d;
      idx_q       <= idx_d;
      zero_q      <= zero_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
endmodule

[rtl/core/critically_damped_spring_step.sv]
// Critically damped spring step: one exact closed-form update per transfer, velocity kept
// inside. One item is worked at a time. A zero time step skips the arithmetic. Any other
// step runs a bit-serial divide with a 33+FracBits-bit quotient for the damping rate, a
// six-step range reduction, and 34 products of 64 by 64 bits through one 32x32 multiplier.
// When the exponential underflows to zero the range reduction and the series are skipped
// and only six products are made in all. A finished result waits in an output register and
// the next item can be taken meanwhile; that item's result then waits until the previous
// one has been transferred.
module critically_damped_spring_step
  #(parameter int unsigned FracBits = cdss_pkg::FRAC_BITS_DEF)
  (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [cdss_pkg::HL_W-1:0] cfg_wdata_i,
  cdss_upd_if.sink                  upd_i,
  cdss_res_if.source                res_o
);
  import cdss_pkg::*;

  cmd_t cmd;
  sts_t sts;

  cdss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (upd_i.valid),
    .in_ready_o  (upd_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  cdss_dp #(.FracBits(FracBits)) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .current_position_i (upd_i.current_position),
    .target_position_i  (upd_i.target_position),
    .time_step_i        (upd_i.time_step),
    .new_position_o     (res_o.new_position),
    .new_velocity_o     (res_o.new_velocity)
  );
endmodule

[rtl/core/cdss_chk.sv]
// port checker for the spring step, bound to the top level
module cdss_chk (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic signed [cdss_pkg::POS_W-1:0] in_pos,
  input logic        [cdss_pkg::DT_W-1:0]  in_dt,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [cdss_pkg::POS_W-1:0] out_pos,
  input logic signed [cdss_pkg::POS_W-1:0] out_vel
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped before transfer");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> ($stable(out_pos) && $stable(out_vel)))
    else $error("stalled result changed");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while an item is in flight");

  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared with no item in flight");

  a_zero_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid && in_ready && (in_dt == '0) && !out_valid)
      |-> ##3 (out_valid && (out_pos == $past(in_pos, 3))))
    else $error("zero time step did not return the position");

endmodule

bind critically_damped_spring_step cdss_chk u_cdss_chk (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (upd_i.valid),
  .in_ready  (upd_i.ready),
  .in_pos    (upd_i.current_position),
  .in_dt     (upd_i.time_step),
  .out_valid (res_o.valid),
  .out_ready (res_o.ready),
  .out_pos   (res_o.new_position),
  .out_vel   (res_o.new_velocity)
);
